### rtl/core/uspl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted unique pair list: shared package
// Request and response types, entry layout, action and status codes.
// ----------------------------------------------------------------------------
package uspl_pkg;

  // Default number of cells in the list.
  localparam int LIST_DEPTH_DEF = 32;

  // Action codes of a request.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  // Status codes of a response.
  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_DUPLICATE   = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_READ_OK     = 3'd3;
  localparam logic [2:0] ST_READ_BEYOND = 3'd4;
  localparam logic [2:0] ST_CLEARED     = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] entry_value;
    logic [2:0] entry_priority;
    logic [4:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_value;
    logic [2:0] out_priority;
    logic [4:0] insert_position;
    logic [5:0] entry_count;
  } out_rsp_t;

  // One stored entry.
  typedef struct packed {
    logic [7:0] value;
    logic [2:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic       shift;
    entry_t     entry;
    logic [4:0] read_index;
  } cell_cmd_t;

endpackage

### rtl/core/uspl_cell.sv
// ----------------------------------------------------------------------------
// Sorted unique pair list: one cell
// Holds one entry, compares it against the broadcast entry and takes either
// the new entry or its left neighbor's entry when an insert shifts the row.
// ----------------------------------------------------------------------------
module uspl_cell import uspl_pkg::*; #(
  parameter int Idx  = 0,
  parameter int CntW = 6
) (
  input  logic                clk_i,
  input  cell_cmd_t           cmd_i,
  input  logic [CntW-1:0]     count_i,
  input  entry_t              left_i,
  input  logic                left_before_i,
  output entry_t              entry_o,
  output logic                before_o,
  output logic                match_o,
  output logic [ENTRY_W-1:0]  rd_data_o
);

  entry_t entry_q, entry_d;
  logic   occupied;
  logic   rd_hit;

  assign occupied = count_i > CntW'(Idx);

  // The stored entry sorts ahead of the new one.
  assign before_o = occupied &&
                    ((entry_q.prio < cmd_i.entry.prio) ||
                     ((entry_q.prio == cmd_i.entry.prio) &&
                      (entry_q.value < cmd_i.entry.value)));

  assign match_o = occupied && (entry_q.value == cmd_i.entry.value);

  assign rd_hit    = (Idx < 32) && (cmd_i.read_index == 5'(Idx));
  assign rd_data_o = rd_hit ? entry_q : '0;
  assign entry_o   = entry_q;

  // Cells ahead of the insert point keep their entry; the first cell at or
  // past it takes the new entry, the rest take their left neighbor's.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift && !before_o) begin
      entry_d = left_before_i ? cmd_i.entry : left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### rtl/core/unique_sorted_pair_list_unit.sv
// ----------------------------------------------------------------------------
// Sorted unique pair list: top level
// A row of cells keeps (value, priority) entries in ascending order and
// answers insert, read and clear requests.
// ----------------------------------------------------------------------------
// Output: a response is registered at the clock edge that accepts its request.
// Throughput: one request per cycle unless a stalled response blocks the input;
//   every cell compares and shifts in the same cycle; the insert point comes from the row's one-hot flags.
// Reset: the fill count and the response valid clear at once; the cell
//   entries are undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module unique_sorted_pair_list_unit import uspl_pkg::*; #(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int CntW = $clog2(LIST_DEPTH + 1);
  localparam int CmpW = (CntW > 5) ? CntW : 5;

  // Fill count, response register and its valid flag.
  logic [CntW-1:0] count_q, count_d;
  out_rsp_t        rsp_q, rsp_d;
  logic            out_valid_q, out_valid_d;

  logic            accept;
  cell_cmd_t       cmd;

  // Per-cell flags and data of the row.
  entry_t                cell_entry [LIST_DEPTH];
  entry_t                left_entry [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] before_vec;
  logic [LIST_DEPTH-1:0] left_before_vec;
  logic [LIST_DEPTH-1:0] match_vec;
  logic [ENTRY_W-1:0]    rd_data [LIST_DEPTH];

  // Row-wide results, encoded from one-hot flags.
  logic [4:0]         ins_pos;
  logic [4:0]         dup_pos;
  logic [ENTRY_W-1:0] rd_word;
  entry_t             rd_entry;
  logic               dup;
  logic               full;
  logic               read_ok;

  // A new request is taken whenever the response register is free or is
  // being emptied in this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign dup     = |match_vec;
  assign full    = count_q == CntW'(LIST_DEPTH);
  assign read_ok = CmpW'(in_req_i.read_index) < CmpW'(count_q);

  // The row shifts only for an insert that is neither a duplicate nor
  // refused because every cell is occupied.
  always_comb begin
    cmd.shift      = accept && (in_req_i.action == ACT_INSERT) && !dup && !full;
    cmd.entry      = '{value: in_req_i.entry_value, prio: in_req_i.entry_priority};
    cmd.read_index = in_req_i.read_index;
  end

  // Each cell sees its left neighbor; the first cell sees the new entry
  // with a neighbor that sorts ahead, so it takes the new entry whenever
  // it is at or past the insert point.
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_entry[k]      = cmd.entry;
      assign left_before_vec[k] = 1'b1;
    end else begin : g_rest
      assign left_entry[k]      = cell_entry[k-1];
      assign left_before_vec[k] = before_vec[k-1];
    end

    uspl_cell #(
      .Idx  (k),
      .CntW (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .count_i       (count_q),
      .left_i        (left_entry[k]),
      .left_before_i (left_before_vec[k]),
      .entry_o       (cell_entry[k]),
      .before_o      (before_vec[k]),
      .match_o       (match_vec[k]),
      .rd_data_o     (rd_data[k])
    );
  end

  // Occupied cells that sort ahead form a prefix, so exactly one cell has a
  // neighbor ahead and is not ahead itself: that is the insert point. Values
  // are unique, so at most one cell matches. Only the read-selected cell
  // drives nonzero read data. Positions keep their low five bits.
  always_comb begin
    ins_pos = '0;
    dup_pos = '0;
    rd_word = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (!before_vec[k] && left_before_vec[k]) begin
        ins_pos = ins_pos | 5'(k);
      end
      if (match_vec[k]) begin
        dup_pos = dup_pos | 5'(k);
      end
      rd_word = rd_word | rd_data[k];
    end
  end

  assign rd_entry = rd_word;

  // Response and fill count for the request at the input.
  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    unique case (in_req_i.action) inside
      ACT_INSERT: begin
        if (dup) begin
          rsp_d.status          = ST_DUPLICATE;
          rsp_d.insert_position = dup_pos;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.status          = ST_INSERTED;
          rsp_d.insert_position = ins_pos;
          count_d               = count_q + CntW'(1);
        end
      end
      ACT_CLEAR: begin
        rsp_d.status = ST_CLEARED;
        count_d      = '0;
      end
      ACT_READ, ACT_SPARE: begin
        if (read_ok) begin
          rsp_d.status       = ST_READ_OK;
          rsp_d.out_value    = rd_entry.value;
          rsp_d.out_priority = rd_entry.prio;
        end else begin
          rsp_d.status = ST_READ_BEYOND;
        end
      end
      default: begin
        rsp_d.status = ST_READ_BEYOND;
      end
    endcase
    rsp_d.entry_count = 6'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef ASSERT_OFF
  // The fill count never runs past the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(LIST_DEPTH))
    else $error("fill count exceeds list depth");

  // Stored values are unique, so at most one cell can match.
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("more than one cell matches the value");

  // A successful insert grows the list by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance the fill count");

  // A clear response always reports an empty list.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (rsp_q.status == ST_CLEARED)) |-> (rsp_q.entry_count == '0))
    else $error("clear response reports stored entries");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique pair list: testbench
// Drives insert, read, clear and spare requests into the list and checks
// every response against a cycle-free predictor of the sorted list.
// ----------------------------------------------------------------------------
module tb_top;
  import uspl_pkg::*;

  localparam int DEPTH = LIST_DEPTH_DEF;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  // When low, neither the request side nor the response side idles, so the
  // block sees back-to-back traffic.
  bit gaps_on = 1'b1;

  int mismatch_count = 0;

  // Predicted contents of the list, kept in sorted order.
  logic [7:0] list_vals [DEPTH];
  logic [2:0] list_pris [DEPTH];
  int         list_fill = 0;

  // Responses the block still owes, oldest first.
  out_rsp_t list_rsp_queue [$];

  unique_sorted_pair_list_unit #(
    .LIST_DEPTH (DEPTH)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Length of one idle stretch: mostly none, sometimes short and now and
  // then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Applies one request to the predicted list and returns the response the
  // block must give for it. Entries sort by priority first, then by value;
  // uniqueness is on the value alone.
  function automatic out_rsp_t sorted_list_apply(in_req_t req);
    out_rsp_t rsp;
    int       k;
    int       slot;
    rsp = '0;
    case (req.action)
      ACT_INSERT: begin
        slot = -1;
        for (k = 0; k < list_fill; k++) begin
          if (slot < 0 && list_vals[k] == req.entry_value) slot = k;
        end
        if (slot >= 0) begin
          // The duplicate check wins even when the list is full.
          rsp.status          = ST_DUPLICATE;
          rsp.insert_position = slot[4:0];
        end else if (list_fill >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < list_fill &&
                 (list_pris[slot] < req.entry_priority ||
                  (list_pris[slot] == req.entry_priority &&
                   list_vals[slot] < req.entry_value))) begin
            slot++;
          end
          for (k = list_fill; k > slot; k--) begin
            list_vals[k] = list_vals[k - 1];
            list_pris[k] = list_pris[k - 1];
          end
          list_vals[slot]     = req.entry_value;
          list_pris[slot]     = req.entry_priority;
          list_fill++;
          rsp.status          = ST_INSERTED;
          rsp.insert_position = slot[4:0];
        end
      end
      ACT_CLEAR: begin
        list_fill  = 0;
        rsp.status = ST_CLEARED;
      end
      default: begin
        // The spare action code behaves as a read.
        if (req.read_index < list_fill) begin
          rsp.status       = ST_READ_OK;
          rsp.out_value    = list_vals[req.read_index];
          rsp.out_priority = list_pris[req.read_index];
        end else begin
          rsp.status = ST_READ_BEYOND;
        end
      end
    endcase
    rsp.entry_count = list_fill[5:0];
    return rsp;
  endfunction

  function automatic bit value_stored(logic [7:0] v);
    int k;
    for (k = 0; k < list_fill; k++) begin
      if (list_vals[k] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Presents one request and returns at the edge that accepts it. Valid is
  // left high, so a following request with no gap goes out back to back.
  task automatic issue_request(input in_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    list_rsp_queue.push_back(sorted_list_apply(req));
  endtask

  // Fields that an action does not use get random values, so that all of
  // their bits toggle.
  task automatic do_insert(input logic [7:0] v, input logic [2:0] p);
    in_req_t req;
    req = {ACT_INSERT, v, p, 5'($urandom)};
    issue_request(req);
  endtask

  task automatic do_read(input logic [4:0] idx, input bit spare);
    in_req_t req;
    req = {spare ? ACT_SPARE : ACT_READ, 8'($urandom), 3'($urandom), idx};
    issue_request(req);
  endtask

  task automatic do_clear();
    in_req_t req;
    req = {ACT_CLEAR, 8'($urandom), 3'($urandom), 5'($urandom)};
    issue_request(req);
  endtask

  // Holds the request side idle until every owed response has come back.
  task automatic wait_all_responses();
    if (in_valid) in_valid <= 1'b0;
    while (list_rsp_queue.size() != 0) @(posedge clk);
  endtask

  // Response side: stalls of random length, separated by free stretches.
  initial begin : rsp_stall_gen
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every accepted response is compared with the oldest owed one.
  always @(posedge clk) begin : rsp_check
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (list_rsp_queue.size() == 0) begin
        $error("response accepted with no request outstanding");
        mismatch_count++;
      end else begin
        want = list_rsp_queue.pop_front();
        check_field("status", want.status, out_rsp.status);
        check_field("out_value", want.out_value, out_rsp.out_value);
        check_field("out_priority", want.out_priority, out_rsp.out_priority);
        check_field("insert_position", want.insert_position, out_rsp.insert_position);
        check_field("entry_count", want.entry_count, out_rsp.entry_count);
      end
    end
  end

  // Reads and clears on an empty list, including the spare action code.
  task automatic test_empty_list();
    do_clear();
    do_read(5'd0, 1'b0);
    do_read(5'd31, 1'b0);
    do_read(5'd0, 1'b1);
  endtask

  // Extreme values and priorities, duplicates with a different priority,
  // and reads of every stored position plus one beyond the end.
  task automatic test_insert_order();
    int k;
    do_insert(8'd255, 3'd7);
    do_insert(8'd0, 3'd0);
    do_insert(8'd128, 3'd3);
    do_insert(8'd0, 3'd7);
    do_insert(8'd255, 3'd0);
    do_insert(8'd1, 3'd7);
    for (k = 0; k <= 4; k++) do_read(k[4:0], 1'b0);
    do_read(5'd2, 1'b1);
    do_clear();
    do_read(5'd0, 1'b0);
  endtask

  // Fills the list to the last cell, then checks the full rejection, a
  // duplicate while full, reads at both ends and a clear. Runs with no
  // idling on either side.
  task automatic test_full_list();
    logic [7:0] v;
    int         k;
    gaps_on = 1'b0;
    do_clear();
    for (k = 0; k < DEPTH; k++) begin
      do v = 8'($urandom); while (value_stored(v));
      do_insert(v, 3'($urandom));
    end
    do v = 8'($urandom); while (value_stored(v));
    do_insert(v, 3'($urandom));
    do_insert(list_vals[$urandom_range(0, DEPTH - 1)], 3'($urandom));
    do_read(5'd31, 1'b0);
    do_read(5'd0, 1'b0);
    do_read(5'd31, 1'b1);
    do_clear();
    gaps_on = 1'b1;
  endtask

  // Bursts of inserts, mostly on a fresh list, mixed with reads, forced
  // duplicates and a little noise. A narrow value range makes duplicates
  // common; a wide one lets the list fill up and overflow.
  task automatic test_random_traffic();
    logic [31:0] rnd;
    in_req_t     noise;
    int          sent;
    int          burst;
    int          span;
    int          k;
    int          r;
    sent = 0;
    while (sent < 1400) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 6) begin
        do_clear();
        sent++;
      end
      span  = ($urandom_range(0, 2) == 0) ? 40 : 255;
      burst = $urandom_range(1, 44);
      for (k = 0; k < burst; k++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          do_insert(8'($urandom_range(0, span)), 3'($urandom));
        end else if (r < 87) begin
          do_read(5'($urandom), 1'b0);
        end else if (r < 92) begin
          do_read(5'($urandom), 1'b1);
        end else if (r < 96 && list_fill > 0) begin
          do_insert(list_vals[$urandom_range(0, list_fill - 1)], 3'($urandom));
        end else begin
          rnd   = $urandom;
          noise = rnd[$bits(in_req_t)-1:0];
          issue_request(noise);
        end
        sent++;
      end
      // Now and then the request side waits for every response.
      if ($urandom_range(0, 7) == 0) wait_all_responses();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_insert_order();
    wait_all_responses();
    test_full_list();
    test_random_traffic();

    // Drain, then idle so that a spurious late response can still show up.
    wait_all_responses();
    repeat (4) @(posedge clk);
    if (list_rsp_queue.size() != 0) begin
      $error("%0d responses never arrived", list_rsp_queue.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // A correct run with every stall at its longest takes around 1 ms.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
